@@ hw/rtl/hufd_pkg.sv @@
// Shared types and constants for the Huffman tree build and walk decoder.
package hufd_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int SYM_AW      = $clog2(MAX_SYMBOLS);
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int NCNT_W      = $clog2(NODE_DEPTH + 1);
    localparam int NW_W        = WEIGHT_BITS + 8;
    localparam logic [15:0] WEIGHT_MASK = 16'((64'd1 << WEIGHT_BITS) - 64'd1);

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    localparam logic [1:0] RK_SYMBOL = 2'd0;
    localparam logic [1:0] RK_BUILT  = 2'd1;
    localparam logic [1:0] RK_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  entry_symbol;
        logic [15:0] entry_weight;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] decoded_symbol;
        logic       last_of_run;
    } out_t;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] addr;
        logic [NW_W-1:0]    weight;
        logic [NODE_AW-1:0] left;
        logic [NODE_AW-1:0] right;
    } nd_wr_t;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] addr;
        logic               val;
    } par_wr_t;

    typedef struct packed {
        logic [NW_W-1:0]    weight;
        logic [NODE_AW-1:0] left;
        logic [NODE_AW-1:0] right;
        logic               parent;
    } nd_rd_t;

endpackage

@@ hw/rtl/hufd_node_ram.sv @@
// Node store: weight, children and parent flag per tree node, one shared read port.
module hufd_node_ram (
    input  logic                          clk,
    input  logic [hufd_pkg::NODE_AW-1:0]  rd_addr,
    input  hufd_pkg::nd_wr_t              wr,
    input  hufd_pkg::par_wr_t             pwr,
    output hufd_pkg::nd_rd_t              rd
);
    import hufd_pkg::*;

    logic [NW_W-1:0]    weight_mem [NODE_DEPTH];
    logic [NODE_AW-1:0] left_mem   [NODE_DEPTH];
    logic [NODE_AW-1:0] right_mem  [NODE_DEPTH];
    logic               parent_mem [NODE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            weight_mem[wr.addr] <= wr.weight;
            left_mem[wr.addr]   <= wr.left;
            right_mem[wr.addr]  <= wr.right;
        end
        if (pwr.we)
            parent_mem[pwr.addr] <= pwr.val;
        rd.weight <= weight_mem[rd_addr];
        rd.left   <= left_mem[rd_addr];
        rd.right  <= right_mem[rd_addr];
        rd.parent <= parent_mem[rd_addr];
    end

endmodule

@@ hw/rtl/huffman_tree_build_decode.sv @@
// Top level: table load, tree build by repeated min scans, and bitwise tree walk.
// A build clears the parent flags of the entries, then each of the entry_count-1
// merges scans all current nodes through the node memory, one node per cycle, then
// writes the merged node and flags both its children. A data byte is walked bit by
// bit, each bit a node-memory read, then a select; a one-symbol table gives its eight
// results. A reject result is registered and appears in the cycle after the beat; a
// build result appears when the build ends. Results come out strobed by result_valid
// for one cycle each and cannot be stalled; start is ignored while busy is high.
module huffman_tree_build_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  hufd_pkg::in_t    item,
    output logic             result_valid,
    output hufd_pkg::out_t   result
);
    import hufd_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_CLR      = 11'b00000000010,
        S_SCAN     = 11'b00000000100,
        S_MRG_N    = 11'b00000001000,
        S_MRG_A    = 11'b00000010000,
        S_MRG_B    = 11'b00000100000,
        S_W_RD     = 11'b00001000000,
        S_W_SEL    = 11'b00010000000,
        S_W_END    = 11'b00100000000,
        S_ONE_RD   = 11'b01000000000,
        S_ONE_EMIT = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   entry_cnt_reg, entry_cnt_next;
    logic [NCNT_W-1:0]  node_cnt_reg, node_cnt_next;
    logic [NODE_AW-1:0] walk_reg, walk_next;
    logic               ready_reg, ready_next;
    logic [NCNT_W-1:0]  idx_reg, idx_next;
    logic               rvld_reg, rvld_next;
    logic [NODE_AW-1:0] ridx_reg, ridx_next;
    logic               best_vld_reg, best_vld_next;
    logic [NODE_AW-1:0] best_idx_reg, best_idx_next;
    logic [NW_W-1:0]    best_w_reg, best_w_next;
    logic               sec_vld_reg, sec_vld_next;
    logic [NODE_AW-1:0] sec_idx_reg, sec_idx_next;
    logic [NW_W-1:0]    sec_w_reg, sec_w_next;
    logic [7:0]         byte_reg, byte_next;
    logic [2:0]         bcnt_reg, bcnt_next;
    logic               pend_reg, pend_next;
    logic               outv_reg, outv_next;
    out_t               out_reg, out_next;

    logic [NODE_AW-1:0] rd_addr;
    nd_wr_t             nd_wr;
    par_wr_t            par_wr;
    nd_rd_t             nd_rd;

    logic [7:0]         leaf_mem [MAX_SYMBOLS];
    logic [7:0]         leaf_q;
    logic               leaf_we, leaf_re;
    logic [SYM_AW-1:0]  leaf_wa, leaf_ra;
    logic [7:0]         leaf_wd;

    logic [NODE_AW-1:0] root;
    logic [NODE_AW-1:0] pos_fix;
    logic [NODE_AW-1:0] child;
    logic [CNT_W-1:0]   ec;
    logic [NCNT_W-1:0]  full_nodes;
    logic [NCNT_W-1:0]  ncnt_inc;

    hufd_node_ram u_node_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr      (nd_wr),
        .pwr     (par_wr),
        .rd      (nd_rd)
    );

    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_wa] <= leaf_wd;
        if (leaf_re)
            leaf_q <= leaf_mem[leaf_ra];
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = outv_reg;
    assign result       = out_reg;

    assign root       = NODE_AW'(node_cnt_reg - NCNT_W'(1));
    assign full_nodes = (NCNT_W'(entry_cnt_reg) << 1) - NCNT_W'(1);
    assign ncnt_inc   = node_cnt_reg + NCNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        entry_cnt_next = entry_cnt_reg;
        node_cnt_next  = node_cnt_reg;
        walk_next      = walk_reg;
        ready_next     = ready_reg;
        idx_next       = idx_reg;
        rvld_next      = rvld_reg;
        ridx_next      = ridx_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_w_next    = best_w_reg;
        sec_vld_next   = sec_vld_reg;
        sec_idx_next   = sec_idx_reg;
        sec_w_next     = sec_w_reg;
        byte_next      = byte_reg;
        bcnt_next      = bcnt_reg;
        pend_next      = pend_reg;
        outv_next      = 1'b0;
        out_next       = '0;
        rd_addr        = '0;
        nd_wr          = '0;
        par_wr         = '0;
        leaf_we        = 1'b0;
        leaf_wa        = '0;
        leaf_wd        = '0;
        leaf_re        = 1'b0;
        leaf_ra        = '0;
        ec             = entry_cnt_reg;
        child          = '0;

        if ((NCNT_W'(walk_reg) >= node_cnt_reg) ||
            (NCNT_W'(walk_reg) < NCNT_W'(entry_cnt_reg)))
            pos_fix = root;
        else
            pos_fix = walk_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.kind)
                        KIND_LOAD:
                        begin
                            if (ready_reg)
                            begin
                                ec            = '0;
                                ready_next    = 1'b0;
                                node_cnt_next = '0;
                                walk_next     = '0;
                            end
                            if (ec == CNT_W'(MAX_SYMBOLS))
                            begin
                                outv_next            = 1'b1;
                                out_next.result_kind = RK_REJECT;
                                out_next.last_of_run = 1'b1;
                            end
                            else
                            begin
                                leaf_we        = 1'b1;
                                leaf_wa        = ec[SYM_AW-1:0];
                                leaf_wd        = item.entry_symbol;
                                nd_wr.we       = 1'b1;
                                nd_wr.addr     = NODE_AW'(ec);
                                nd_wr.weight   = NW_W'(item.entry_weight & WEIGHT_MASK);
                                entry_cnt_next = ec + CNT_W'(1);
                            end
                        end
                        KIND_BUILD:
                        begin
                            if (entry_cnt_reg == '0)
                            begin
                                outv_next            = 1'b1;
                                out_next.result_kind = RK_REJECT;
                                out_next.last_of_run = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_CLR;
                            end
                        end
                        KIND_DATA:
                        begin
                            if (!ready_reg)
                            begin
                                outv_next            = 1'b1;
                                out_next.result_kind = RK_REJECT;
                                out_next.last_of_run = 1'b1;
                            end
                            else if (entry_cnt_reg == CNT_W'(1))
                                state_next = S_ONE_RD;
                            else
                            begin
                                byte_next  = item.data_byte;
                                bcnt_next  = '0;
                                pend_next  = 1'b0;
                                state_next = S_W_RD;
                            end
                        end
                        default:
                        begin
                            outv_next            = 1'b1;
                            out_next.result_kind = RK_REJECT;
                            out_next.last_of_run = 1'b1;
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                par_wr.we   = 1'b1;
                par_wr.addr = idx_reg[NODE_AW-1:0];
                par_wr.val  = 1'b0;
                idx_next    = idx_reg + NCNT_W'(1);
                if (idx_next == NCNT_W'(entry_cnt_reg))
                begin
                    node_cnt_next = NCNT_W'(entry_cnt_reg);
                    if (entry_cnt_reg == CNT_W'(1))
                    begin
                        walk_next            = '0;
                        ready_next           = 1'b1;
                        outv_next            = 1'b1;
                        out_next.result_kind = RK_BUILT;
                        out_next.last_of_run = 1'b1;
                        state_next           = S_IDLE;
                    end
                    else
                    begin
                        idx_next      = '0;
                        rvld_next     = 1'b0;
                        best_vld_next = 1'b0;
                        sec_vld_next  = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (idx_reg < node_cnt_reg)
                begin
                    rd_addr   = idx_reg[NODE_AW-1:0];
                    idx_next  = idx_reg + NCNT_W'(1);
                    rvld_next = 1'b1;
                    ridx_next = idx_reg[NODE_AW-1:0];
                end
                else
                    rvld_next = 1'b0;

                // running lowest and second lowest; ties keep the earlier node
                if (rvld_reg && !nd_rd.parent)
                begin
                    if (!best_vld_reg || (nd_rd.weight < best_w_reg))
                    begin
                        sec_vld_next  = best_vld_reg;
                        sec_idx_next  = best_idx_reg;
                        sec_w_next    = best_w_reg;
                        best_vld_next = 1'b1;
                        best_idx_next = ridx_reg;
                        best_w_next   = nd_rd.weight;
                    end
                    else if (!sec_vld_reg || (nd_rd.weight < sec_w_reg))
                    begin
                        sec_vld_next = 1'b1;
                        sec_idx_next = ridx_reg;
                        sec_w_next   = nd_rd.weight;
                    end
                end

                if ((idx_reg == node_cnt_reg) && !rvld_reg)
                    state_next = S_MRG_N;
            end

            S_MRG_N:
            begin
                nd_wr.we     = 1'b1;
                nd_wr.addr   = node_cnt_reg[NODE_AW-1:0];
                nd_wr.weight = best_w_reg + sec_w_reg;
                nd_wr.left   = best_idx_reg;
                nd_wr.right  = sec_idx_reg;
                par_wr.we    = 1'b1;
                par_wr.addr  = node_cnt_reg[NODE_AW-1:0];
                par_wr.val   = 1'b0;
                state_next   = S_MRG_A;
            end

            S_MRG_A:
            begin
                par_wr.we   = 1'b1;
                par_wr.addr = best_idx_reg;
                par_wr.val  = 1'b1;
                state_next  = S_MRG_B;
            end

            S_MRG_B:
            begin
                par_wr.we     = 1'b1;
                par_wr.addr   = sec_idx_reg;
                par_wr.val    = 1'b1;
                node_cnt_next = ncnt_inc;
                if (ncnt_inc == full_nodes)
                begin
                    walk_next            = node_cnt_reg[NODE_AW-1:0];
                    ready_next           = 1'b1;
                    outv_next            = 1'b1;
                    out_next.result_kind = RK_BUILT;
                    out_next.last_of_run = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    idx_next      = '0;
                    rvld_next     = 1'b0;
                    best_vld_next = 1'b0;
                    sec_vld_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_W_RD:
            begin
                rd_addr    = pos_fix;
                state_next = S_W_SEL;
            end

            S_W_SEL:
            begin
                child = byte_reg[7] ? nd_rd.right : nd_rd.left;
                if (NCNT_W'(child) >= node_cnt_reg)
                    child = root;
                if (NCNT_W'(child) < NCNT_W'(entry_cnt_reg))
                begin
                    leaf_re = 1'b1;
                    leaf_ra = child[SYM_AW-1:0];
                    // the held symbol goes out now that another one follows
                    if (pend_reg)
                    begin
                        outv_next               = 1'b1;
                        out_next.result_kind    = RK_SYMBOL;
                        out_next.decoded_symbol = leaf_q;
                        out_next.last_of_run    = 1'b0;
                    end
                    pend_next = 1'b1;
                    walk_next = root;
                end
                else
                    walk_next = child;
                byte_next = {byte_reg[6:0], 1'b0};
                bcnt_next = bcnt_reg + 3'd1;
                state_next = (bcnt_reg == 3'd7) ? S_W_END : S_W_RD;
            end

            S_W_END:
            begin
                if (pend_reg)
                begin
                    outv_next               = 1'b1;
                    out_next.result_kind    = RK_SYMBOL;
                    out_next.decoded_symbol = leaf_q;
                    out_next.last_of_run    = 1'b1;
                end
                pend_next  = 1'b0;
                state_next = S_IDLE;
            end

            S_ONE_RD:
            begin
                leaf_re    = 1'b1;
                leaf_ra    = '0;
                bcnt_next  = '0;
                state_next = S_ONE_EMIT;
            end

            S_ONE_EMIT:
            begin
                outv_next               = 1'b1;
                out_next.result_kind    = RK_SYMBOL;
                out_next.decoded_symbol = leaf_q;
                out_next.last_of_run    = (bcnt_reg == 3'd7);
                bcnt_next               = bcnt_reg + 3'd1;
                if (bcnt_reg == 3'd7)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entry_cnt_reg <= '0;
            node_cnt_reg  <= '0;
            walk_reg      <= '0;
            ready_reg     <= 1'b0;
            idx_reg       <= '0;
            rvld_reg      <= 1'b0;
            best_vld_reg  <= 1'b0;
            sec_vld_reg   <= 1'b0;
            bcnt_reg      <= '0;
            pend_reg      <= 1'b0;
            outv_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entry_cnt_reg <= entry_cnt_next;
            node_cnt_reg  <= node_cnt_next;
            walk_reg      <= walk_next;
            ready_reg     <= ready_next;
            idx_reg       <= idx_next;
            rvld_reg      <= rvld_next;
            best_vld_reg  <= best_vld_next;
            sec_vld_reg   <= sec_vld_next;
            bcnt_reg      <= bcnt_next;
            pend_reg      <= pend_next;
            outv_reg      <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg     <= ridx_next;
        best_idx_reg <= best_idx_next;
        best_w_reg   <= best_w_next;
        sec_idx_reg  <= sec_idx_next;
        sec_w_reg    <= sec_w_next;
        byte_reg     <= byte_next;
        out_reg      <= out_next;
    end

    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_cnt_reg <= CNT_W'(MAX_SYMBOLS))
        else $error("entry count beyond table size");

    a_tree_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && ready_reg) |-> (node_cnt_reg == full_nodes))
        else $error("built tree has wrong node count");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind != RK_SYMBOL) |-> result.last_of_run)
        else $error("build or reject result not marked last");

    a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MRG_N) |-> (best_vld_reg && sec_vld_reg &&
                                    best_idx_reg != sec_idx_reg))
        else $error("merge without two distinct free nodes");

endmodule
